// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the voxel update RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define PMVU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("voxel update assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define PMVU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("voxel update assertion failed");

`endif

// ===== hdl/pmvu_pkg.sv =====
// Package with shared constants and register codes of the voxel update block.
`timescale 1ns / 1ps
`default_nettype none

package pmvu_pkg;

  localparam int DEF_VALUE_WIDTH = 32;
  localparam int DEF_FRAC_BITS   = 16;
  localparam int DEF_MAX_SUBSETS = 1024;

  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int SUBSET_CNT_W = 11;

  localparam logic [SUBSET_CNT_W-1:0] SUBSET_CNT_RST = SUBSET_CNT_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_FACTOR = 3'd0,
    REG_MAX_FACTOR = 3'd1,
    REG_PEN_ENABLE = 3'd2,
    REG_PEN_BETA   = 3'd3,
    REG_SUBSETS    = 3'd4
  } cfg_reg_e;

endpackage

`default_nettype wire

// ===== hdl/pmvu_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sideband payload.
`timescale 1ns / 1ps
`default_nettype none

module pmvu_div #(
  parameter int DW = 32,
  parameter int QW = 32,
  parameter int PW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] low_i,
  input  logic [DW-1:0] den_i,
  input  logic [PW-1:0] payload_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic [PW-1:0] payload_o
);

  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [QW-1:0] low_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [PW-1:0] pl_q  [QW];
  logic          vld_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] r_in;
    logic [QW-1:0] q_in;
    logic [QW-1:0] l_in;
    logic [DW-1:0] d_in;
    logic [PW-1:0] p_in;
    logic          v_in;
    logic [DW:0]   cand;
    logic          ge;

    if (k == 0) begin : g_first
      assign r_in = rem_i;
      assign q_in = '0;
      assign l_in = low_i;
      assign d_in = den_i;
      assign p_in = payload_i;
      assign v_in = valid_i;
    end else begin : g_rest
      assign r_in = rem_q[k-1];
      assign q_in = quo_q[k-1];
      assign l_in = low_q[k-1];
      assign d_in = den_q[k-1];
      assign p_in = pl_q[k-1];
      assign v_in = vld_q[k-1];
    end

    assign cand = {r_in, l_in[QW-1]};
    assign ge   = cand >= {1'b0, d_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? DW'(cand - {1'b0, d_in}) : cand[DW-1:0];
        quo_q[k] <= {q_in[QW-2:0], ge};
        low_q[k] <= {l_in[QW-2:0], 1'b0};
        den_q[k] <= d_in;
        pl_q[k]  <= p_in;
      end
    end
  end

  assign valid_o   = vld_q[QW-1];
  assign quo_o     = quo_q[QW-1];
  assign payload_o = pl_q[QW-1];

endmodule

`default_nettype wire

// ===== hdl/pmvu_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, with sideband payload.
`timescale 1ns / 1ps
`default_nettype none

module pmvu_sqrt #(
  parameter int RW = 94,
  parameter int PW = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [RW-1:0]   rad_i,
  input  logic [PW-1:0]   payload_i,
  output logic            valid_o,
  output logic [RW/2-1:0] root_o,
  output logic [PW-1:0]   payload_o
);

  localparam int RTW  = RW / 2;
  localparam int REMW = RTW + 2;

  logic [REMW-1:0] rem_q  [RTW];
  logic [RTW-1:0]  root_q [RTW];
  logic [RW-1:0]   rad_q  [RTW];
  logic [PW-1:0]   pl_q   [RTW];
  logic            vld_q  [RTW];

  for (genvar k = 0; k < RTW; k++) begin : g_stage
    logic [REMW-1:0] r_in;
    logic [RTW-1:0]  t_in;
    logic [RW-1:0]   a_in;
    logic [PW-1:0]   p_in;
    logic            v_in;
    logic [REMW+1:0] cand;
    logic [REMW+1:0] trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign r_in = '0;
      assign t_in = '0;
      assign a_in = rad_i;
      assign p_in = payload_i;
      assign v_in = valid_i;
    end else begin : g_rest
      assign r_in = rem_q[k-1];
      assign t_in = root_q[k-1];
      assign a_in = rad_q[k-1];
      assign p_in = pl_q[k-1];
      assign v_in = vld_q[k-1];
    end

    // The partial remainder never exceeds twice the partial root.
    assign cand  = {r_in, a_in[RW-1:RW-2]};
    assign trial = {2'b00, t_in, 2'b01};
    assign ge    = cand >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? REMW'(cand - trial) : cand[REMW-1:0];
        root_q[k] <= {t_in[RTW-2:0], ge};
        rad_q[k]  <= {a_in[RW-3:0], 2'b00};
        pl_q[k]   <= p_in;
      end
    end
  end

  assign valid_o   = vld_q[RTW-1];
  assign root_o    = root_q[RTW-1];
  assign payload_o = pl_q[RTW-1];

endmodule

`default_nettype wire

// ===== hdl/penalized_mlem_voxel_update.sv =====
// Top level of the penalized MLEM voxel update pipeline.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// Penalized MLEM voxel update. Each input transfer carries one voxel (current
// value, sensitivity, back-projected correction sum and penalty derivative) and
// produces exactly one output transfer with the updated value and two flags.
// The block is a fully pipelined datapath: a new voxel can enter in every clock
// cycle unless the pipe is stalled, so the sustained rate is one voxel per cycle
// outside stalls. The pipe is built around the two bit-per-stage dividers
// (update factor and final quotient) and the bit-per-stage square root. The
// whole pipe advances together; it stalls only when its last stage holds a
// result and the output register is still waiting for its transfer. During
// such a stall the input is not ready either, even if bubbles remain elsewhere
// in the pipe.
// Configuration registers may be written only when no voxel is in flight; the
// configuration port is always ready. All values are unsigned fixed point with
// FRAC_BITS fraction bits, the derivative is two's complement. Zero sensitivity
// or, with the penalty enabled, a non-positive denominator forces the value to
// zero and raises bad_input; overflow saturates to full scale and raises saturated.
module penalized_mlem_voxel_update #(
  parameter int VALUE_WIDTH = pmvu_pkg::DEF_VALUE_WIDTH,
  parameter int FRAC_BITS   = pmvu_pkg::DEF_FRAC_BITS,
  parameter int MAX_SUBSETS = pmvu_pkg::DEF_MAX_SUBSETS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write channel.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pmvu_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pmvu_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Voxel input channel.
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [VALUE_WIDTH-1:0]          current_value_i,
  input  logic [VALUE_WIDTH-1:0]          sensitivity_i,
  input  logic [VALUE_WIDTH-1:0]          correction_sum_i,
  input  logic signed [VALUE_WIDTH-1:0]   penalty_derivative_i,
  // Result channel.
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [VALUE_WIDTH-1:0]          new_value_o,
  output logic                            bad_input_o,
  output logic                            saturated_o
);

  localparam int W     = VALUE_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int SCW   = pmvu_pkg::SUBSET_CNT_W;
  localparam int CDW   = pmvu_pkg::CFG_DATA_W;
  localparam int NB    = $clog2(MAX_SUBSETS + 1);
  localparam int NSW   = NB + W;
  localparam int BMW   = NSW + 1;
  localparam int HB    = (BMW + 1) / 2;
  localparam int HT    = BMW - HB;
  localparam int HHW   = 2 * HT;
  localparam int HLW   = HT + HB;
  localparam int LLW   = 2 * HB;
  localparam int BM2W  = 2 * BMW;
  localparam int BSW   = 2 * W;
  localparam int NEMW  = NB + W;
  localparam int TPW   = BSW + NEMW;
  localparam int TW    = TPW + 2 - F;
  localparam int RAD0  = ((BM2W > TW) ? BM2W : TW) + 1;
  localparam int RADW  = RAD0 + (RAD0 % 2);
  localparam int RTW   = RADW / 2;
  localparam int DENW  = ((BMW > RTW) ? BMW : RTW) + 1;
  localparam int NUMW  = NB + 1 + 2 * W;
  localparam int NHW   = NUMW - W;
  localparam int CMPW  = (NHW > DENW) ? NHW : DENW;

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  logic [W-1:0]   min_q, max_q, beta_q;
  logic           pen_q;
  logic [SCW-1:0] sc_q;
  logic [CDW+W-1:0] cfg_ext;

  assign cfg_ready_o = 1'b1;
  assign cfg_ext     = {{W{1'b0}}, cfg_data_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= '0;
      max_q  <= '0;
      pen_q  <= 1'b0;
      beta_q <= '0;
      sc_q   <= pmvu_pkg::SUBSET_CNT_RST;
    end else if (cfg_valid_i) begin
      unique case (pmvu_pkg::cfg_reg_e'(cfg_index_i))
        pmvu_pkg::REG_MIN_FACTOR: min_q  <= cfg_ext[W-1:0];
        pmvu_pkg::REG_MAX_FACTOR: max_q  <= cfg_ext[W-1:0];
        pmvu_pkg::REG_PEN_ENABLE: pen_q  <= cfg_data_i[0];
        pmvu_pkg::REG_PEN_BETA:   beta_q <= cfg_ext[W-1:0];
        pmvu_pkg::REG_SUBSETS:    sc_q   <= cfg_data_i[SCW-1:0];
        default: ;
      endcase
    end
  end

  // Effective subset count: zero counts as one, large counts clip to the maximum.
  logic [31:0]   sc_ext, n_sel;
  logic [NB-1:0] n_eff;

  assign sc_ext = 32'(sc_q);
  assign n_sel  = (sc_ext == 32'd0) ? 32'd1 :
                  (sc_ext > 32'(MAX_SUBSETS)) ? 32'(MAX_SUBSETS) : sc_ext;
  assign n_eff  = n_sel[NB-1:0];

  // ---------------------------------------------------------------------------
  // Stage types.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [W-1:0]   x;
    logic [W-1:0]   d;
    logic [BSW-1:0] bs;
    logic [NSW-1:0] ns;
    logic           bad;
    logic           fsat;
  } d1_pl_t;

  typedef struct packed {
    d1_pl_t       pl;
    logic [W-1:0] rem0;
    logic [W-1:0] low;
    logic [W-1:0] s;
  } st_a_t;

  typedef struct packed {
    logic [W-1:0]   fac;
    logic           sat;
    logic [W-1:0]   x;
    logic [W-1:0]   d;
    logic [BSW-1:0] bs;
    logic [NSW-1:0] ns;
    logic           bad;
  } st_b_t;

  typedef struct packed {
    logic [BSW-1:0] prod;
    logic           sat;
    logic [W-1:0]   d;
    logic [BSW-1:0] bs;
    logic [NSW-1:0] ns;
    logic           bad;
  } st_c_t;

  typedef struct packed {
    logic [W-1:0]   em;
    logic           sat;
    logic [BMW-1:0] bm;
    logic           bneg;
    logic [BSW-1:0] bs;
    logic [NSW-1:0] ns;
    logic           bad;
  } st_d_t;

  typedef struct packed {
    logic [HHW-1:0]  hh;
    logic [HLW-1:0]  hl;
    logic [LLW-1:0]  ll;
    logic [NEMW-1:0] nem;
    logic [BSW-1:0]  nsl_em;
    logic [NEMW-1:0] nsh_em;
    logic [BSW-1:0]  bs;
    logic [W-1:0]    em;
    logic            sat;
    logic [BMW-1:0]  bm;
    logic            bneg;
    logic            bad;
  } st_e_t;

  typedef struct packed {
    logic [BM2W-1:0] bm2;
    logic [NUMW-1:0] num;
    logic [BSW-1:0]  p00;
    logic [NEMW-1:0] p01;
    logic [BSW-1:0]  p10;
    logic [NEMW-1:0] p11;
    logic [W-1:0]    em;
    logic            sat;
    logic [BMW-1:0]  bm;
    logic            bneg;
    logic            bad;
  } st_f_t;

  typedef struct packed {
    logic [BM2W-1:0] bm2;
    logic [TW-1:0]   t;
    logic [NUMW-1:0] num;
    logic [W-1:0]    em;
    logic            sat;
    logic [BMW-1:0]  bm;
    logic            bneg;
    logic            bad;
  } st_g_t;

  typedef struct packed {
    logic [NUMW-1:0] num;
    logic [W-1:0]    em;
    logic            sat;
    logic [BMW-1:0]  bm;
    logic            bneg;
    logic            bad;
  } sq_pl_t;

  typedef struct packed {
    sq_pl_t          pl;
    logic [RADW-1:0] rad;
  } st_h_t;

  typedef struct packed {
    logic [W-1:0] em;
    logic         sat;
    logic         bad;
    logic         bad2;
    logic         qsat;
  } d2_pl_t;

  typedef struct packed {
    d2_pl_t          pl;
    logic [DENW-1:0] rem0;
    logic [W-1:0]    low;
    logic [DENW-1:0] den;
  } st_i_t;

  // ---------------------------------------------------------------------------
  // Global pipeline advance. The whole pipe moves together unless its last
  // stage holds a result that the output register cannot take yet.
  // ---------------------------------------------------------------------------
  logic adv;
  logic v1, vsq, v2;
  logic va_q, vb_q, vc_q, vd_q, ve_q, vf_q, vg_q, vh_q, vi_q;
  logic out_valid_q;

  assign adv        = !v2 || !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
      vg_q <= 1'b0;
      vh_q <= 1'b0;
      vi_q <= 1'b0;
    end else if (adv) begin
      va_q <= in_valid_i;
      vb_q <= v1;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
      vf_q <= ve_q;
      vg_q <= vf_q;
      vh_q <= vg_q;
      vi_q <= vsq;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: capture the voxel, form beta*s and n*s, and set up the factor
  // division. The quotient overflows exactly when the upper numerator part
  // reaches the sensitivity, so only VALUE_WIDTH quotient bits are computed.
  // ---------------------------------------------------------------------------
  st_a_t a_d, a_q;
  logic [W-1:0] c_hi;

  assign c_hi = W'(correction_sum_i >> (W - F));

  always_comb begin
    a_d.pl.x    = current_value_i;
    a_d.pl.d    = $unsigned(penalty_derivative_i);
    a_d.pl.bs   = BSW'(beta_q) * BSW'(sensitivity_i);
    a_d.pl.ns   = NSW'(n_eff) * NSW'(sensitivity_i);
    a_d.pl.bad  = (sensitivity_i == '0);
    a_d.pl.fsat = (c_hi >= sensitivity_i);
    a_d.rem0    = c_hi;
    a_d.low     = W'(correction_sum_i << F);
    a_d.s       = sensitivity_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q <= a_d;
    end
  end

  logic [W-1:0] q1;
  d1_pl_t       p1;
  logic [$bits(d1_pl_t)-1:0] p1_raw;

  pmvu_div #(
    .DW (W),
    .QW (W),
    .PW ($bits(d1_pl_t))
  ) u_div_factor (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .valid_i   (va_q),
    .rem_i     (a_q.rem0),
    .low_i     (a_q.low),
    .den_i     (a_q.s),
    .payload_i (a_q.pl),
    .valid_o   (v1),
    .quo_o     (q1),
    .payload_o (p1_raw)
  );

  assign p1 = d1_pl_t'(p1_raw);

  // ---------------------------------------------------------------------------
  // Stage B: saturate and clamp the update factor. The minimum is applied
  // first, so the maximum wins when the two bounds cross; the maximum clamp
  // also clears the overflow flag of the factor.
  // ---------------------------------------------------------------------------
  st_b_t b_d, b_q;

  always_comb begin
    b_d.fac = p1.fsat ? '1 : q1;
    b_d.sat = p1.fsat;
    if (min_q != '0 && b_d.fac < min_q) begin
      b_d.fac = min_q;
    end
    if (max_q != '0 && b_d.fac > max_q) begin
      b_d.fac = max_q;
      b_d.sat = 1'b0;
    end
    b_d.x   = p1.x;
    b_d.d   = p1.d;
    b_d.bs  = p1.bs;
    b_d.ns  = p1.ns;
    b_d.bad = p1.bad;
  end

  // Stage C: EM product of the factor and the current value.
  st_c_t c_d, c_q;

  always_comb begin
    c_d.prod = BSW'(b_q.fac) * BSW'(b_q.x);
    c_d.sat  = b_q.sat;
    c_d.d    = b_q.d;
    c_d.bs   = b_q.bs;
    c_d.ns   = b_q.ns;
    c_d.bad  = b_q.bad;
  end

  // ---------------------------------------------------------------------------
  // Stage D: rescale and saturate the EM value, and form b = n*s + d as a
  // magnitude with a sign.
  // ---------------------------------------------------------------------------
  st_d_t d_d, d_q;
  logic           dneg;
  logic [W-1:0]   dmag;
  logic [BMW-1:0] ns_e, dm_e;

  assign dneg = c_q.d[W-1];
  assign dmag = dneg ? W'(~c_q.d + 1'b1) : c_q.d;
  assign ns_e = BMW'(c_q.ns);
  assign dm_e = BMW'(dmag);

  always_comb begin
    d_d.sat = c_q.sat;
    if (|c_q.prod[BSW-1:W+F]) begin
      d_d.em  = '1;
      d_d.sat = 1'b1;
    end else begin
      d_d.em  = c_q.prod[W+F-1:F];
    end
    if (!dneg) begin
      d_d.bm   = ns_e + dm_e;
      d_d.bneg = 1'b0;
    end else if (ns_e >= dm_e) begin
      d_d.bm   = ns_e - dm_e;
      d_d.bneg = 1'b0;
    end else begin
      d_d.bm   = dm_e - ns_e;
      d_d.bneg = 1'b1;
    end
    d_d.bs  = c_q.bs;
    d_d.ns  = c_q.ns;
    d_d.bad = c_q.bad;
  end

  // ---------------------------------------------------------------------------
  // Stage E: first partial products of b^2, n*em and n*s*em.
  // ---------------------------------------------------------------------------
  st_e_t e_d, e_q;
  logic [HT-1:0] bh;
  logic [HB-1:0] bl;

  assign bh = d_q.bm[BMW-1:HB];
  assign bl = d_q.bm[HB-1:0];

  always_comb begin
    e_d.hh     = HHW'(bh) * HHW'(bh);
    e_d.hl     = HLW'(bh) * HLW'(bl);
    e_d.ll     = LLW'(bl) * LLW'(bl);
    e_d.nem    = NEMW'(n_eff) * NEMW'(d_q.em);
    e_d.nsl_em = BSW'(d_q.ns[W-1:0]) * BSW'(d_q.em);
    e_d.nsh_em = NEMW'(d_q.ns[NSW-1:W]) * NEMW'(d_q.em);
    e_d.bs     = d_q.bs;
    e_d.em     = d_q.em;
    e_d.sat    = d_q.sat;
    e_d.bm     = d_q.bm;
    e_d.bneg   = d_q.bneg;
    e_d.bad    = d_q.bad;
  end

  // ---------------------------------------------------------------------------
  // Stage F: sum b^2, finish the numerator 2*n*s*em, and split the penalty
  // product (beta*s)*(n*em) into four partial products.
  // ---------------------------------------------------------------------------
  st_f_t f_d, f_q;

  always_comb begin
    f_d.bm2 = (BM2W'(e_q.hh) << (2 * HB)) + (BM2W'(e_q.hl) << (HB + 1)) + BM2W'(e_q.ll);
    f_d.num = ((NUMW'(e_q.nsh_em) << W) + NUMW'(e_q.nsl_em)) << 1;
    f_d.p00 = BSW'(e_q.bs[W-1:0]) * BSW'(e_q.nem[W-1:0]);
    f_d.p01 = NEMW'(e_q.bs[W-1:0]) * NEMW'(e_q.nem[NEMW-1:W]);
    f_d.p10 = BSW'(e_q.bs[BSW-1:W]) * BSW'(e_q.nem[W-1:0]);
    f_d.p11 = NEMW'(e_q.bs[BSW-1:W]) * NEMW'(e_q.nem[NEMW-1:W]);
    f_d.em   = e_q.em;
    f_d.sat  = e_q.sat;
    f_d.bm   = e_q.bm;
    f_d.bneg = e_q.bneg;
    f_d.bad  = e_q.bad;
  end

  // Stage G: penalty term 4*n*beta*s*em, truncated by FRAC_BITS.
  st_g_t g_d, g_q;
  logic [TPW-1:0] tp;
  logic [TPW+1:0] tp4;

  assign tp  = TPW'(f_q.p00) + (TPW'(f_q.p01) << W) + (TPW'(f_q.p10) << W)
             + (TPW'(f_q.p11) << BSW);
  assign tp4 = {tp, 2'b00};

  always_comb begin
    g_d.bm2  = f_q.bm2;
    g_d.t    = tp4[TPW+1:F];
    g_d.num  = f_q.num;
    g_d.em   = f_q.em;
    g_d.sat  = f_q.sat;
    g_d.bm   = f_q.bm;
    g_d.bneg = f_q.bneg;
    g_d.bad  = f_q.bad;
  end

  // Stage H: radicand b^2 + penalty term.
  st_h_t h_d, h_q;

  always_comb begin
    h_d.rad     = RADW'(g_q.bm2) + RADW'(g_q.t);
    h_d.pl.num  = g_q.num;
    h_d.pl.em   = g_q.em;
    h_d.pl.sat  = g_q.sat;
    h_d.pl.bm   = g_q.bm;
    h_d.pl.bneg = g_q.bneg;
    h_d.pl.bad  = g_q.bad;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_q <= b_d;
      c_q <= c_d;
      d_q <= d_d;
      e_q <= e_d;
      f_q <= f_d;
      g_q <= g_d;
      h_q <= h_d;
    end
  end

  logic [RTW-1:0] sq;
  sq_pl_t         psq;
  logic [$bits(sq_pl_t)-1:0] psq_raw;

  pmvu_sqrt #(
    .RW (RADW),
    .PW ($bits(sq_pl_t))
  ) u_sqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .valid_i   (vh_q),
    .rad_i     (h_q.rad),
    .payload_i (h_q.pl),
    .valid_o   (vsq),
    .root_o    (sq),
    .payload_o (psq_raw)
  );

  assign psq = sq_pl_t'(psq_raw);

  // ---------------------------------------------------------------------------
  // Stage I: denominator b + sqrt(...), written as sqrt(...) - |b| when b is
  // negative, the checks for a denominator that is not positive, and the
  // setup of the final division with its overflow test.
  // ---------------------------------------------------------------------------
  st_i_t i_d, i_q;
  logic [DENW-1:0] sq_e, bm_e;
  logic [NHW-1:0]  num_hi;

  assign sq_e   = DENW'(sq);
  assign bm_e   = DENW'(psq.bm);
  assign num_hi = psq.num[NUMW-1:W];

  always_comb begin
    if (psq.bneg) begin
      i_d.den     = sq_e - bm_e;
      i_d.pl.bad2 = (sq_e <= bm_e);
    end else begin
      i_d.den     = bm_e + sq_e;
      i_d.pl.bad2 = (bm_e + sq_e == '0);
    end
    i_d.pl.qsat = CMPW'(num_hi) >= CMPW'(i_d.den);
    i_d.pl.em   = psq.em;
    i_d.pl.sat  = psq.sat;
    i_d.pl.bad  = psq.bad;
    i_d.rem0    = DENW'(num_hi);
    i_d.low     = psq.num[W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      i_q <= i_d;
    end
  end

  logic [W-1:0] q2;
  d2_pl_t       p2;
  logic [$bits(d2_pl_t)-1:0] p2_raw;

  pmvu_div #(
    .DW (DENW),
    .QW (W),
    .PW ($bits(d2_pl_t))
  ) u_div_final (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .valid_i   (vi_q),
    .rem_i     (i_q.rem0),
    .low_i     (i_q.low),
    .den_i     (i_q.den),
    .payload_i (i_q.pl),
    .valid_o   (v2),
    .quo_o     (q2),
    .payload_o (p2_raw)
  );

  assign p2 = d2_pl_t'(p2_raw);

  // ---------------------------------------------------------------------------
  // Result selection and output register. The output register takes a result
  // whenever it is empty or its current result leaves in the same cycle.
  // ---------------------------------------------------------------------------
  logic [W-1:0] res_val_d, res_val_q;
  logic         res_bad_d, res_bad_q;
  logic         res_sat_d, res_sat_q;
  logic         out_load;

  always_comb begin
    res_val_d = '0;
    res_bad_d = 1'b0;
    res_sat_d = 1'b0;
    if (p2.bad) begin
      res_bad_d = 1'b1;
    end else if (!pen_q) begin
      res_val_d = p2.em;
      res_sat_d = p2.sat;
    end else if (p2.bad2) begin
      res_bad_d = 1'b1;
    end else if (p2.qsat) begin
      res_val_d = '1;
      res_sat_d = 1'b1;
    end else begin
      res_val_d = q2;
      res_sat_d = p2.sat;
    end
  end

  assign out_load = v2 && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_val_q <= res_val_d;
      res_bad_q <= res_bad_d;
      res_sat_q <= res_sat_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign new_value_o = res_val_q;
  assign bad_input_o = res_bad_q;
  assign saturated_o = res_sat_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `PMVU_ASSERT_NOW(a_bad_forces_zero, out_valid_o && bad_input_o,
                   new_value_o == '0 && !saturated_o)
  `PMVU_ASSERT_NXT(a_input_enters, in_valid_i && in_ready_o, va_q)
  `PMVU_ASSERT_NXT(a_last_holds, v2 && !adv, v2)
  `PMVU_ASSERT_NXT(a_result_loads, v2 && adv, out_valid_q)

endmodule

`default_nettype wire
